// ----- rtl/ar3d_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and sine table functions for the 3D axis rotation block.
package ar3d_pkg;

  localparam int DEF_COORD_WIDTH    = 16;
  localparam int DEF_TRIG_FRAC_BITS = 15;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 9;
  localparam int AXIS_WIDTH      = 2;
  localparam int ANGLE_WIDTH     = 9;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_SELECT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_DEGREES = 2'd1;

  localparam int DEG_WIDTH     = 10;
  localparam int TAB_DEPTH     = 91;
  localparam int TAB_IDX_WIDTH = 7;

  localparam logic [DEG_WIDTH-1:0] DEG_QUARTER       = 10'd90;
  localparam logic [DEG_WIDTH-1:0] DEG_HALF          = 10'd180;
  localparam logic [DEG_WIDTH-1:0] DEG_THREE_QUARTER = 10'd270;
  localparam logic [DEG_WIDTH-1:0] DEG_FULL          = 10'd360;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] SERIES_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                               64'd156, 64'd210};

  typedef enum logic [AXIS_WIDTH-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic  valid;
    axis_t axis;
  } stage_ctl_t;

  typedef struct packed {
    logic                     neg;
    logic [TAB_IDX_WIDTH-1:0] idx;
  } trig_sel_t;

  // Odd power series of sine for 0..90 degrees in unsigned Q2.30
  function automatic logic [63:0] sine_q30(input int unsigned deg);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / SERIES_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  // Magnitude in Q1.frac, rounded and saturated below 1.0
  function automatic logic [63:0] sine_fixed(input int unsigned deg, input int frac);
    logic [63:0] r;
    logic [63:0] maxv;
    r    = sine_q30(deg);
    maxv = (64'd1 << frac) - 64'd1;
    if (frac < 30) begin
      r = (r + (64'd1 << (29 - frac))) >> (30 - frac);
    end
    if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // Fold 0..359 degrees into a quarter-wave index and a sign
  function automatic trig_sel_t fold_angle(input logic [DEG_WIDTH-1:0] a);
    trig_sel_t sel;
    priority if (a <= DEG_QUARTER) begin
      sel.neg = 1'b0;
      sel.idx = TAB_IDX_WIDTH'(a);
    end else if (a <= DEG_HALF) begin
      sel.neg = 1'b0;
      sel.idx = TAB_IDX_WIDTH'(DEG_HALF - a);
    end else if (a <= DEG_THREE_QUARTER) begin
      sel.neg = 1'b1;
      sel.idx = TAB_IDX_WIDTH'(a - DEG_HALF);
    end else begin
      sel.neg = 1'b1;
      sel.idx = TAB_IDX_WIDTH'(DEG_FULL - a);
    end
    return sel;
  endfunction

endpackage

// ----- rtl/axis_rotation_3d_point.sv -----
`timescale 1ns / 1ps
// Top level of the 3D principal-axis point rotator.
//
// Usage:
//   Configuration: pulse cfg_write with cfg_index 0 to set the axis
//   (0 x, 1 y, 2 z, 3 pass-through) or cfg_index 1 to set the angle in
//   whole degrees (taken modulo 360). Other indexes are ignored. The
//   sine/cosine coefficients are looked up from a 91-entry quarter-wave
//   table (the folded index is registered, then the coefficients) and
//   are ready for a request issued the cycle after the write.
//   Requests: a point is taken at a clock edge where start is high and
//   busy is low. busy is never raised: one request per cycle is taken.
//   Results: done is high for one cycle with rotated_x/y/z and clipped.
//   The path is a four-stage pipeline (operand select, multiply, sum
//   and round, saturate), so throughput is one point per clock.
//   There is no result back-pressure; the receiver must take each result.
//   Reset: synchronous rst empties the pipeline, selects the x axis and
//   sets the angle to zero (sine 0, cosine full scale).
module axis_rotation_3d_point #(
  parameter int COORD_WIDTH    = ar3d_pkg::DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = ar3d_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ar3d_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ar3d_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_WIDTH-1:0]        point_x,
  input  logic signed [COORD_WIDTH-1:0]        point_y,
  input  logic signed [COORD_WIDTH-1:0]        point_z,
  output logic                                 done,
  output logic signed [COORD_WIDTH-1:0]        rotated_x,
  output logic signed [COORD_WIDTH-1:0]        rotated_y,
  output logic signed [COORD_WIDTH-1:0]        rotated_z,
  output logic                                 clipped
);
  import ar3d_pkg::*;

  localparam int SUM_WIDTH = COORD_WIDTH + TRIG_FRAC_BITS + 2;

  axis_t                          axis_select;
  logic signed [TRIG_FRAC_BITS:0] sine_value;
  logic signed [TRIG_FRAC_BITS:0] cosine_value;
  logic                           accept;
  stage_ctl_t                     sum_ctl;
  logic signed [SUM_WIDTH-1:0]    sum_first;
  logic signed [SUM_WIDTH-1:0]    sum_second;
  logic signed [COORD_WIDTH-1:0]  coord_u;
  logic signed [COORD_WIDTH-1:0]  coord_v;
  logic signed [COORD_WIDTH-1:0]  coord_w;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ar3d_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .axis_select (axis_select),
    .sine_value  (sine_value),
    .cosine_value(cosine_value)
  );

  ar3d_mix #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .axis_select (axis_select),
    .sine_value  (sine_value),
    .cosine_value(cosine_value),
    .sum_ctl     (sum_ctl),
    .sum_first   (sum_first),
    .sum_second  (sum_second),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .coord_w     (coord_w)
  );

  ar3d_round #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .sum_ctl   (sum_ctl),
    .sum_first (sum_first),
    .sum_second(sum_second),
    .coord_u   (coord_u),
    .coord_v   (coord_v),
    .coord_w   (coord_w),
    .done      (done),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .rotated_z (rotated_z),
    .clipped   (clipped)
  );

  a_request_done : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("request produced no result");

  a_done_has_request : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without a request");

endmodule

// ----- rtl/ar3d_trig.sv -----
`timescale 1ns / 1ps
// Configuration registers and sine/cosine coefficient generation from the quarter-wave table.
module ar3d_trig #(
  parameter int TRIG_FRAC_BITS = ar3d_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ar3d_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ar3d_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output ar3d_pkg::axis_t                      axis_select,
  output logic signed [TRIG_FRAC_BITS:0]       sine_value,
  output logic signed [TRIG_FRAC_BITS:0]       cosine_value
);
  import ar3d_pkg::*;

  localparam logic signed [TRIG_FRAC_BITS:0] TRIG_MAX = {1'b0, {TRIG_FRAC_BITS{1'b1}}};

  logic [TRIG_FRAC_BITS-1:0] sine_tab [TAB_DEPTH];

  for (genvar d = 0; d < TAB_DEPTH; d++) begin : g_tab
    localparam logic [TRIG_FRAC_BITS-1:0] ENTRY =
      TRIG_FRAC_BITS'(sine_fixed(d, TRIG_FRAC_BITS));
    assign sine_tab[d] = ENTRY;
  end

  logic                 axis_wr;
  logic                 angle_wr;
  logic [DEG_WIDTH-1:0] angle_raw;
  logic [DEG_WIDTH-1:0] angle_wrapped;
  logic [DEG_WIDTH-1:0] cos_raw;
  logic [DEG_WIDTH-1:0] cos_wrapped;
  trig_sel_t            sine_sel_next;
  trig_sel_t            cos_sel_next;
  trig_sel_t            sine_sel;
  trig_sel_t            cos_sel;
  logic                 trig_load;
  logic signed [TRIG_FRAC_BITS:0] sine_mag;
  logic signed [TRIG_FRAC_BITS:0] cos_mag;

  assign axis_wr  = cfg_write && (cfg_index == REG_AXIS_SELECT);
  assign angle_wr = cfg_write && (cfg_index == REG_ANGLE_DEGREES);

  always_comb begin
    angle_raw     = DEG_WIDTH'(cfg_data[ANGLE_WIDTH-1:0]);
    angle_wrapped = (angle_raw >= DEG_FULL) ? angle_raw - DEG_FULL : angle_raw;
    cos_raw       = angle_wrapped + DEG_QUARTER;
    cos_wrapped   = (cos_raw >= DEG_FULL) ? cos_raw - DEG_FULL : cos_raw;
    sine_sel_next = fold_angle(angle_wrapped);
    cos_sel_next  = fold_angle(cos_wrapped);
  end

  assign sine_mag = {1'b0, sine_tab[sine_sel.idx]};
  assign cos_mag  = {1'b0, sine_tab[cos_sel.idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select  <= AXIS_X;
      trig_load    <= 1'b0;
      sine_sel     <= '0;
      cos_sel      <= '0;
      sine_value   <= '0;
      cosine_value <= TRIG_MAX;
    end else begin
      trig_load <= angle_wr;
      if (axis_wr) begin
        axis_select <= axis_t'(cfg_data[AXIS_WIDTH-1:0]);
      end
      if (angle_wr) begin
        sine_sel <= sine_sel_next;
        cos_sel  <= cos_sel_next;
      end
      if (trig_load) begin
        sine_value   <= sine_sel.neg ? -sine_mag : sine_mag;
        cosine_value <= cos_sel.neg ? -cos_mag : cos_mag;
      end
    end
  end

  a_zero_angle : assert property (@(posedge clk) disable iff (rst)
    angle_wr && (cfg_data[ANGLE_WIDTH-1:0] == '0) |=> ##1
      (sine_value == '0) && (cosine_value > 0))
    else $error("zero angle did not give zero sine");

  a_trig_hold : assert property (@(posedge clk) disable iff (rst)
    !trig_load |=> $stable(sine_value) && $stable(cosine_value))
    else $error("coefficients changed without an angle write");

endmodule

// ----- rtl/ar3d_mix.sv -----
`timescale 1ns / 1ps
// Operand select, coefficient products and rounded sums: pipeline stages one to three.
module ar3d_mix #(
  parameter int COORD_WIDTH    = ar3d_pkg::DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = ar3d_pkg::DEF_TRIG_FRAC_BITS,
  parameter int SUM_WIDTH      = COORD_WIDTH + TRIG_FRAC_BITS + 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [COORD_WIDTH-1:0]   point_x,
  input  logic signed [COORD_WIDTH-1:0]   point_y,
  input  logic signed [COORD_WIDTH-1:0]   point_z,
  input  ar3d_pkg::axis_t                 axis_select,
  input  logic signed [TRIG_FRAC_BITS:0]  sine_value,
  input  logic signed [TRIG_FRAC_BITS:0]  cosine_value,
  output ar3d_pkg::stage_ctl_t            sum_ctl,
  output logic signed [SUM_WIDTH-1:0]     sum_first,
  output logic signed [SUM_WIDTH-1:0]     sum_second,
  output logic signed [COORD_WIDTH-1:0]   coord_u,
  output logic signed [COORD_WIDTH-1:0]   coord_v,
  output logic signed [COORD_WIDTH-1:0]   coord_w
);
  import ar3d_pkg::*;

  localparam int PROD_WIDTH = COORD_WIDTH + TRIG_FRAC_BITS + 1;
  localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
    {{(SUM_WIDTH-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

  logic signed [COORD_WIDTH-1:0] u_next;
  logic signed [COORD_WIDTH-1:0] v_next;
  logic signed [COORD_WIDTH-1:0] w_next;

  stage_ctl_t                    s1_ctl;
  logic signed [COORD_WIDTH-1:0] s1_u;
  logic signed [COORD_WIDTH-1:0] s1_v;
  logic signed [COORD_WIDTH-1:0] s1_w;

  stage_ctl_t                    s2_ctl;
  logic signed [COORD_WIDTH-1:0] s2_u;
  logic signed [COORD_WIDTH-1:0] s2_v;
  logic signed [COORD_WIDTH-1:0] s2_w;
  logic signed [PROD_WIDTH-1:0]  prod_cu;
  logic signed [PROD_WIDTH-1:0]  prod_sv;
  logic signed [PROD_WIDTH-1:0]  prod_su;
  logic signed [PROD_WIDTH-1:0]  prod_cv;

  // first mixed output = c*u - s*v, second = s*u + c*v
  always_comb begin
    unique case (axis_select)
      AXIS_X: begin
        u_next = point_y;
        v_next = point_z;
        w_next = point_x;
      end
      AXIS_Y: begin
        u_next = point_z;
        v_next = point_x;
        w_next = point_y;
      end
      AXIS_Z, AXIS_NONE: begin
        u_next = point_x;
        v_next = point_y;
        w_next = point_z;
      end
      default: begin
        u_next = point_x;
        v_next = point_y;
        w_next = point_z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      s2_ctl  <= '0;
      sum_ctl <= '0;
    end else begin
      s1_ctl  <= '{valid: in_valid, axis: axis_select};
      s2_ctl  <= s1_ctl;
      sum_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_u <= u_next;
    s1_v <= v_next;
    s1_w <= w_next;

    s2_u    <= s1_u;
    s2_v    <= s1_v;
    s2_w    <= s1_w;
    prod_cu <= PROD_WIDTH'(s1_u) * PROD_WIDTH'(cosine_value);
    prod_sv <= PROD_WIDTH'(s1_v) * PROD_WIDTH'(sine_value);
    prod_su <= PROD_WIDTH'(s1_u) * PROD_WIDTH'(sine_value);
    prod_cv <= PROD_WIDTH'(s1_v) * PROD_WIDTH'(cosine_value);

    coord_u    <= s2_u;
    coord_v    <= s2_v;
    coord_w    <= s2_w;
    sum_first  <= SUM_WIDTH'(prod_cu) - SUM_WIDTH'(prod_sv) + ROUND_HALF;
    sum_second <= SUM_WIDTH'(prod_su) + SUM_WIDTH'(prod_cv) + ROUND_HALF;
  end

endmodule

// ----- rtl/ar3d_round.sv -----
`timescale 1ns / 1ps
// Final stage: shift to the coordinate grid, saturate and route to the output axes.
module ar3d_round #(
  parameter int COORD_WIDTH    = ar3d_pkg::DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = ar3d_pkg::DEF_TRIG_FRAC_BITS,
  parameter int SUM_WIDTH      = COORD_WIDTH + TRIG_FRAC_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ar3d_pkg::stage_ctl_t          sum_ctl,
  input  logic signed [SUM_WIDTH-1:0]   sum_first,
  input  logic signed [SUM_WIDTH-1:0]   sum_second,
  input  logic signed [COORD_WIDTH-1:0] coord_u,
  input  logic signed [COORD_WIDTH-1:0] coord_v,
  input  logic signed [COORD_WIDTH-1:0] coord_w,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic signed [COORD_WIDTH-1:0] rotated_z,
  output logic                          clipped
);
  import ar3d_pkg::*;

  localparam int Q_WIDTH = SUM_WIDTH - TRIG_FRAC_BITS;
  localparam logic signed [Q_WIDTH-1:0] Q_HI = {3'b000, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [Q_WIDTH-1:0] Q_LO = {3'b111, {(COORD_WIDTH-1){1'b0}}};

  logic signed [Q_WIDTH-1:0]     q_first;
  logic signed [Q_WIDTH-1:0]     q_second;
  logic signed [COORD_WIDTH-1:0] r_first;
  logic signed [COORD_WIDTH-1:0] r_second;
  logic                          clip_first;
  logic                          clip_second;
  logic signed [COORD_WIDTH-1:0] x_next;
  logic signed [COORD_WIDTH-1:0] y_next;
  logic signed [COORD_WIDTH-1:0] z_next;
  logic                          clipped_next;

  assign q_first  = sum_first[SUM_WIDTH-1:TRIG_FRAC_BITS];
  assign q_second = sum_second[SUM_WIDTH-1:TRIG_FRAC_BITS];

  always_comb begin
    clip_first  = 1'b0;
    clip_second = 1'b0;
    priority if (q_first > Q_HI) begin
      r_first    = Q_HI[COORD_WIDTH-1:0];
      clip_first = 1'b1;
    end else if (q_first < Q_LO) begin
      r_first    = Q_LO[COORD_WIDTH-1:0];
      clip_first = 1'b1;
    end else begin
      r_first = q_first[COORD_WIDTH-1:0];
    end
    priority if (q_second > Q_HI) begin
      r_second    = Q_HI[COORD_WIDTH-1:0];
      clip_second = 1'b1;
    end else if (q_second < Q_LO) begin
      r_second    = Q_LO[COORD_WIDTH-1:0];
      clip_second = 1'b1;
    end else begin
      r_second = q_second[COORD_WIDTH-1:0];
    end

    clipped_next = clip_first || clip_second;
    unique case (sum_ctl.axis)
      AXIS_X: begin
        x_next = coord_w;
        y_next = r_first;
        z_next = r_second;
      end
      AXIS_Y: begin
        x_next = r_second;
        y_next = coord_w;
        z_next = r_first;
      end
      AXIS_Z: begin
        x_next = r_first;
        y_next = r_second;
        z_next = coord_w;
      end
      AXIS_NONE: begin
        x_next       = coord_u;
        y_next       = coord_v;
        z_next       = coord_w;
        clipped_next = 1'b0;
      end
      default: begin
        x_next       = coord_u;
        y_next       = coord_v;
        z_next       = coord_w;
        clipped_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ctl.valid) begin
      rotated_x <= x_next;
      rotated_y <= y_next;
      rotated_z <= z_next;
      clipped   <= clipped_next;
    end
  end

  a_pass_no_clip : assert property (@(posedge clk) disable iff (rst)
    sum_ctl.valid && (sum_ctl.axis == AXIS_NONE) |=> !clipped && (rotated_z == $past(coord_w)))
    else $error("pass-through request was altered");

endmodule
